[hdl/psrf_pkg.sv]
// shared types, codes and command word helpers for the point stream ring formatter
package psrf_pkg;

   typedef enum logic [2:0] {
      KIND_REPORT_START  = 3'd0,
      KIND_PACKET_START  = 3'd1,
      KIND_PACKET_BYTE   = 3'd2,
      KIND_PACKET_END    = 3'd3,
      KIND_REFILL        = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      HS_NONE = 2'd0,
      HS_ACK  = 2'd1,
      HS_NACK = 2'd2
   } hs_type;

   typedef enum logic [1:0] {
      REG_REFILL_MINIMUM = 2'd0,
      REG_NACK_THRESHOLD = 2'd1
   } reg_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] REFILL_MINIMUM_RESET = 8'd2;
   localparam logic [7:0] NACK_THRESHOLD_RESET = 8'd20;

   localparam logic [7:0] CMD_OFFSET     = 8'hd3;
   localparam logic [7:0] CMD_START_LINE = 8'hdc;
   localparam logic [6:0] IDLE_COORD_HI  = 7'd6;
   localparam logic [6:0] IDLE_COORD_LO  = 7'd4;

   // per-transaction result flags handed from control to the output formatter
   typedef struct packed {
      hs_type handshake;
      logic   word_valid;
      logic   pop;
      logic   idle_phase;
      logic   byte_dropped;
   } result_type;

   function automatic logic [31:0] make_word(input logic [6:0] x, input logic [6:0] y);
      return {CMD_START_LINE, 1'b0, y, CMD_OFFSET, 1'b0, x};
   endfunction

endpackage

[hdl/psrf_req_if.sv]
// input channel: event kind and packet byte
interface psrf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] payload_byte;

   modport source (output valid, output kind, output payload_byte, input ready);
   modport sink   (input valid, input kind, input payload_byte, output ready);
endinterface

[hdl/psrf_rsp_if.sv]
// result channel: handshake answer, command word and drop flag
interface psrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  handshake;
   logic        word_valid;
   logic [31:0] command_word;
   logic        byte_dropped;

   modport source (output valid, output handshake, output word_valid, output command_word,
                   output byte_dropped, input ready);
   modport sink   (input valid, input handshake, input word_valid, input command_word,
                   input byte_dropped, output ready);
endinterface

[hdl/psrf_csr_if.sv]
// configuration write channel
interface psrf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/psrf_ring_mem.sv]
// byte ring storage: one write port, two registered read ports
module psrf_ring_mem import psrf_pkg::*; #(
   parameter int RING_DEPTH = 256,
   parameter int ADDR_W     = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [7:0]        rd_data_a,
   output logic [7:0]        rd_data_b
);

   logic [7:0] store_ff [RING_DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while the result waits at the output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hdl/psrf_ctrl.sv]
// pointer, skip, latch and config state; result register and channel handshake
module psrf_ctrl import psrf_pkg::*; #(
   parameter int RING_DEPTH = 256,
   parameter int ADDR_W     = 8
) (
   input  logic              clock,
   input  logic              reset,
   psrf_req_if.sink          req,
   psrf_csr_if.sink          csr,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output result_type        result,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr_a,
   output logic [ADDR_W-1:0] mem_rd_addr_b
);

   localparam int PW    = ADDR_W + 1;
   localparam int CMP_W = (ADDR_W > 8) ? ADDR_W : 8;
   localparam logic [PW-1:0]     DEPTH_EXT = PW'(RING_DEPTH);
   localparam logic [ADDR_W-1:0] LAST      = ADDR_W'(RING_DEPTH - 1);

   function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic              skip_ff, skip_in;
   logic [7:0]        latched_ff, latched_in;
   logic              idle_ff, idle_in;
   logic [7:0]        refill_min_ff, refill_min_in;
   logic [7:0]        nack_thr_ff, nack_thr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in, res_next;

   logic              accept;
   logic [ADDR_W-1:0] count;
   logic [ADDR_W-1:0] free;
   logic [CMP_W-1:0]  free_ext;
   logic [CMP_W-1:0]  count_ext;
   logic [7:0]        space_sat;
   logic              full;
   logic              refill_ok;
   logic [ADDR_W-1:0] rp_inc;

   assign req.ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      count = (wp_ff >= rp_ff) ? (wp_ff - rp_ff)
                               : ADDR_W'(PW'(wp_ff) + DEPTH_EXT - PW'(rp_ff));
      free      = LAST - count;
      full      = (count == LAST);
      free_ext  = CMP_W'(free);
      count_ext = CMP_W'(count);
      space_sat = (free_ext > CMP_W'(255)) ? 8'hff : free_ext[7:0];
      // a pair is popped only when at least two bytes are stored
      refill_ok = (count_ext > CMP_W'(refill_min_ff)) && (count_ext >= CMP_W'(2));
      rp_inc    = advance(rp_ff);
   end

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      skip_in    = skip_ff;
      latched_in = latched_ff;
      idle_in    = idle_ff;
      res_next   = '{handshake: HS_NONE, default: 1'b0};
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      if (accept) begin
         case (kind_type'(req.kind))
            KIND_REPORT_START: begin
               wp_in   = wp_ff & ~ADDR_W'(2);
               skip_in = 1'b1;
            end
            KIND_PACKET_START: begin
               latched_in = space_sat;
            end
            KIND_PACKET_BYTE: begin
               // report id byte is swallowed before the full check
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (full) begin
                  res_next.byte_dropped = 1'b1;
               end else begin
                  mem_wr_en = 1'b1;
                  wp_in     = advance(wp_ff);
               end
            end
            KIND_PACKET_END: begin
               res_next.handshake = (latched_ff < nack_thr_ff) ? HS_NACK : HS_ACK;
            end
            KIND_REFILL: begin
               res_next.word_valid = 1'b1;
               if (refill_ok) begin
                  res_next.pop = 1'b1;
                  mem_rd_en    = 1'b1;
                  rp_in        = advance(rp_inc);
               end else begin
                  idle_in             = !idle_ff;
                  res_next.idle_phase = !idle_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      refill_min_in = refill_min_ff;
      nack_thr_in   = nack_thr_ff;
      if (csr.valid) begin
         case (reg_index_type'(csr.index))
            REG_REFILL_MINIMUM: refill_min_in = csr.data;
            REG_NACK_THRESHOLD: nack_thr_in   = csr.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      result_in = accept ? res_next : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         rp_ff         <= '0;
         skip_ff       <= 1'b0;
         latched_ff    <= '0;
         idle_ff       <= 1'b0;
         refill_min_ff <= REFILL_MINIMUM_RESET;
         nack_thr_ff   <= NACK_THRESHOLD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         skip_ff       <= skip_in;
         latched_ff    <= latched_in;
         idle_ff       <= idle_in;
         refill_min_ff <= refill_min_in;
         nack_thr_ff   <= nack_thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign result        = result_ff;
   assign mem_wr_addr   = wp_ff;
   assign mem_wr_data   = req.payload_byte;
   assign mem_rd_addr_a = rp_ff;
   assign mem_rd_addr_b = rp_inc;

endmodule

[hdl/point_stream_ring_formatter.sv]
// top level: ring control, ring storage and command word formatting
//
//   channel | dir | payload                                         | accepted when
//   req_if  | in  | kind, payload_byte                              | valid && ready
//   rsp_if  | out | handshake, word_valid, command_word, byte_dropped| valid && ready
//   csr_if  | in  | index, data                                     | valid && ready
//
// one transaction per cycle if rsp_if is ready; a result is registered for the next cycle
// a refill reads two ring bytes on acceptance through two registered memory read ports
// req_if.ready follows rsp_if.ready whenever a result is held, so one cycle of backpressure
// holds exactly one transaction
// reset (synchronous) clears pointers, skip flag, latched space and idle phase, and loads
// refill_minimum = 2 and nack_threshold = 20; ring contents are not cleared
module point_stream_ring_formatter import psrf_pkg::*; #(
   parameter int RING_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   psrf_req_if.sink   req_if,
   psrf_rsp_if.source rsp_if,
   psrf_csr_if.sink   csr_if
);

   localparam int ADDR_W = $clog2(RING_DEPTH);

   result_type        result;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr_a;
   logic [ADDR_W-1:0] mem_rd_addr_b;
   logic [7:0]        mem_rd_data_a;
   logic [7:0]        mem_rd_data_b;
   logic [6:0]        coord_x;
   logic [6:0]        coord_y;
   logic [6:0]        idle_coord;

   psrf_ctrl #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .csr           (csr_if),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .result        (result),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b)
   );

   psrf_ring_mem #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_ring_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   always_comb begin
      idle_coord = result.idle_phase ? IDLE_COORD_HI : IDLE_COORD_LO;
      coord_x    = result.pop ? mem_rd_data_a[6:0] : idle_coord;
      coord_y    = result.pop ? mem_rd_data_b[6:0] : idle_coord;
   end

   assign rsp_if.handshake    = result.handshake;
   assign rsp_if.word_valid   = result.word_valid;
   assign rsp_if.command_word = result.word_valid ? make_word(coord_x, coord_y) : 32'd0;
   assign rsp_if.byte_dropped = result.byte_dropped;

endmodule

[hdl/psrf_checker.sv]
// port-level checks for the point stream ring formatter, bound to the top level
module psrf_checker import psrf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_handshake,
   input logic        rsp_word_valid,
   input logic [31:0] rsp_command_word,
   input logic        rsp_byte_dropped
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // packet end always answers with ack or nack in the next cycle
   a_end_answers: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == KIND_PACKET_END) |=>
         rsp_valid && (rsp_handshake == HS_ACK || rsp_handshake == HS_NACK))
      else $error("packet end without ack or nack");

   // refill always yields a framed command word
   a_refill_word: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == KIND_REFILL) |=>
         rsp_valid && rsp_word_valid && (rsp_command_word[15:8] == CMD_OFFSET)
         && (rsp_command_word[31:24] == CMD_START_LINE)
         && !rsp_command_word[7] && !rsp_command_word[23])
      else $error("refill without well-formed command word");

   // only a packet byte can report a drop
   a_drop_only_bytes: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind != KIND_PACKET_BYTE) |=> !rsp_byte_dropped)
      else $error("drop flagged for a non-byte transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command_word)
         && $stable(rsp_handshake))
      else $error("stalled result changed");

endmodule

bind point_stream_ring_formatter psrf_checker u_psrf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_kind         (req_if.kind),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_handshake    (rsp_if.handshake),
   .rsp_word_valid   (rsp_if.word_valid),
   .rsp_command_word (rsp_if.command_word),
   .rsp_byte_dropped (rsp_if.byte_dropped)
);
